// ===== hw/rtl/dsl_pkg.sv =====
// ----------------------------------------------------------------------------
// dsl_pkg
// Types, codes and helpers shared by the DDS sweep serial loader modules.
// ----------------------------------------------------------------------------
package dsl_pkg;

  localparam int QueueDepth = 2;

  // request codes
  localparam logic [2:0] REQ_SET   = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_TICK  = 3'd2;
  localparam logic [2:0] REQ_PDOWN = 3'd3;
  localparam logic [2:0] REQ_RESET = 3'd4;

  // pin action codes
  localparam logic [1:0] ACT_CLOCK  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_RESET  = 2'd2;

  // sweep modes
  localparam logic [1:0] MODE_UP     = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_BOUNCE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_LOW  = 3'd0;
  localparam logic [2:0] REG_HIGH = 3'd1;
  localparam logic [2:0] REG_STEP = 3'd2;
  localparam logic [2:0] REG_MODE = 3'd3;

  // final step of each run
  localparam logic [5:0] WORD_LAST  = 6'd40;
  localparam logic [5:0] PDOWN_LAST = 6'd9;
  localparam logic [5:0] RESET_LAST = 6'd43;

  localparam logic [7:0] PDOWN_BYTE = 8'h04;

  // floor(2p/23) as (2p * 713) >> 14, exact for 2p up to 720
  localparam logic [19:0] PHASE_RECIP = 20'd713;
  localparam int          PHASE_SHIFT = 14;
  localparam logic [8:0]  FULL_TURN   = 9'd360;

  typedef enum logic [1:0] {
    CMD_WORD,
    CMD_PDOWN,
    CMD_RESET
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] tuning_word;
    logic [8:0]  phase_deg;
  } req_t;

  typedef struct packed {
    logic [1:0] pin_action;
    logic       data_bit;
    logic       last;
  } pin_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [39:0] word;
  } cmd_t;

  function automatic logic [4:0] phase_word(input logic [8:0] deg);
    logic [8:0]  p;
    logic [19:0] prod;
    p    = (deg > FULL_TURN) ? deg - FULL_TURN : deg;
    prod = {10'd0, p, 1'b0} * PHASE_RECIP;
    return prod[PHASE_SHIFT +: 5];
  endfunction

endpackage

// ===== hw/rtl/dsl_front.sv =====
// ----------------------------------------------------------------------------
// dsl_front
// Takes requests, holds the config registers and the sweep engine, and turns
// each set, tick, power-down or reset request into a load command for the serializer queue.
// ----------------------------------------------------------------------------
module dsl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dsl_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          q_full,
  output logic          push,
  output dsl_pkg::cmd_t cmd
);
  import dsl_pkg::*;

  logic [31:0] sweep_low;
  logic [31:0] sweep_high;
  logic [31:0] sweep_step;
  logic [1:0]  sweep_mode;
  logic [33:0] position;
  logic [33:0] position_next;
  logic        rising;
  logic        rising_next;
  logic        accept;

  logic signed [33:0] lo_s;
  logic signed [33:0] hi_s;
  logic signed [33:0] sum_s;
  logic               go_up;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;

  assign lo_s = $signed({2'b00, sweep_low});
  assign hi_s = $signed({2'b00, sweep_high});

  // one 34-bit add/subtract, then the limit checks
  always_comb begin
    go_up = (sweep_mode == MODE_DOWN) ? 1'b0 :
            (sweep_mode == MODE_BOUNCE) ? rising : 1'b1;
    sum_s = go_up ? $signed(position + {2'b00, sweep_step})
                  : $signed(position - {2'b00, sweep_step});
    position_next = sum_s;
    rising_next   = rising;
    case (sweep_mode)
      MODE_DOWN: begin
        if (sum_s < lo_s) position_next = {2'b00, sweep_high};
      end
      MODE_BOUNCE: begin
        if (sum_s > hi_s || sum_s < lo_s) rising_next = !rising;
      end
      default: begin
        if (sum_s > hi_s) position_next = {2'b00, sweep_low};
      end
    endcase
  end

  always_comb begin
    push = 1'b0;
    cmd  = '{kind: CMD_WORD, word: '0};
    case (req.req_type)
      REQ_SET: begin
        push = accept;
        cmd  = '{kind: CMD_WORD,
                 word: {phase_word(req.phase_deg), 3'b000, req.tuning_word}};
      end
      REQ_TICK: begin
        push = accept;
        cmd  = '{kind: CMD_WORD, word: {8'd0, position[31:0]}};
      end
      REQ_PDOWN: begin
        push = accept;
        cmd  = '{kind: CMD_PDOWN, word: {32'd0, PDOWN_BYTE}};
      end
      REQ_RESET: begin
        push = accept;
        cmd  = '{kind: CMD_RESET, word: '0};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_low  <= '0;
      sweep_high <= '1;
      sweep_step <= 32'd1;
      sweep_mode <= MODE_UP;
      position   <= '0;
      rising     <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW:  sweep_low  <= cfg_data;
          REG_HIGH: sweep_high <= cfg_data;
          REG_STEP: sweep_step <= cfg_data;
          REG_MODE: sweep_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (accept && req.req_type == REQ_START) begin
        position <= (sweep_mode == MODE_DOWN) ? {2'b00, sweep_high}
                                              : {2'b00, sweep_low};
        rising   <= 1'b1;
      end else if (accept && req.req_type == REQ_TICK) begin
        position <= position_next;
        rising   <= rising_next;
      end
    end
  end

endmodule

// ===== hw/rtl/dsl_queue.sv =====
// ----------------------------------------------------------------------------
// dsl_queue
// Small command FIFO between the request front end and the serializer.
// ----------------------------------------------------------------------------
module dsl_queue #(
  parameter int DEPTH = dsl_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dsl_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output dsl_pkg::cmd_t rdata
);
  import dsl_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);

  cmd_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dsl_back.sv =====
// ----------------------------------------------------------------------------
// dsl_back
// Serializer: walks one command through its run of pin actions, one action
// per cycle while the pin channel accepts, into a registered output stage.
// ----------------------------------------------------------------------------
module dsl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  dsl_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          pin_valid,
  input  logic          pin_ready,
  output dsl_pkg::pin_t pin
);
  import dsl_pkg::*;

  logic        busy;
  cmd_kind_t   kind;
  logic [5:0]  step;
  logic [39:0] sreg;
  logic        adv;
  logic [1:0]  act;
  logic        is_last;

  assign q_pop = !busy && !q_empty;
  assign adv   = !pin_valid || pin_ready;

  always_comb begin
    act     = ACT_CLOCK;
    is_last = 1'b0;
    case (kind)
      CMD_WORD: begin
        is_last = (step == WORD_LAST);
        act     = is_last ? ACT_UPDATE : ACT_CLOCK;
      end
      CMD_PDOWN: begin
        is_last = (step == PDOWN_LAST);
        act     = (is_last || step == '0) ? ACT_UPDATE : ACT_CLOCK;
      end
      CMD_RESET: begin
        is_last = (step == RESET_LAST);
        // opener clock, reset pulse, update, then a zero word and update
        if (step == 6'd1) act = ACT_RESET;
        else if (step == 6'd2 || is_last) act = ACT_UPDATE;
        else act = ACT_CLOCK;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && busy) begin
      pin.pin_action <= act;
      pin.data_bit   <= (act == ACT_CLOCK) ? sreg[0] : 1'b0;
      pin.last       <= is_last;
    end
    if (q_pop) begin
      kind <= q_data.kind;
      sreg <= q_data.word;
      step <= '0;
    end else if (adv && busy) begin
      step <= step + 1'b1;
      // reset runs carry an all-zero word, so the opener clock may shift too
      if (act == ACT_CLOCK) sreg <= {1'b0, sreg[39:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pin_valid <= 1'b0;
    end else begin
      if (adv) pin_valid <= busy;
      if (q_pop) busy <= 1'b1;
      else if (adv && busy && is_last) busy <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/dds_sweep_serial_loader.sv =====
// ----------------------------------------------------------------------------
// dds_sweep_serial_loader
// Turns set, sweep, power-down and chip-reset requests into a stream of
// serial pin actions for a DDS chip's load interface.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one request; pin channel (valid/ready)
//   carries one pin action per transfer, last marks the end of a run.
//   Config writes (cfg_we/cfg_index/cfg_data) take effect next cycle and
//   should only be issued while no run is pending.
//   Set and sweep tick give 41 actions, power down 10, chip reset 44; sweep
//   start and unused codes give none.
//   The first action of a run passes through the command queue, the
//   serializer's command load and its registered pin output stage.
//   The serializer emits one action per cycle while pin_ready is high; the
//   pin output goes idle between runs while the next command is loaded, so
//   a new run starts only after the last one is through.
//   A command queue of QUEUE_DEPTH entries lets requests be taken while the
//   serializer is still busy; req_ready drops when it is full.
//   Reset clears the queue, the sweep engine and the registers to defaults.
//   When pin_ready is low the current action holds and the run pauses.
// ----------------------------------------------------------------------------
module dds_sweep_serial_loader #(
  parameter int QUEUE_DEPTH = dsl_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dsl_pkg::req_t req,
  output logic          pin_valid,
  input  logic          pin_ready,
  output dsl_pkg::pin_t pin,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import dsl_pkg::*;

  logic push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t cmd_in;
  cmd_t cmd_out;

  dsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (cmd_in)
  );

  dsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (cmd_out)
  );

  dsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (cmd_out),
    .q_pop     (q_pop),
    .pin_valid (pin_valid),
    .pin_ready (pin_ready),
    .pin       (pin)
  );

endmodule
